FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. The using module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check only outside reset.
`define LSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define LSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Types and constants for the LZSS stream decoder.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int OFFSET_BITS    = 11;
  localparam int LEN_BITS       = 4;
  localparam int MIN_MATCH_BIAS = 1;

  localparam int RING_SIZE       = 2 ** OFFSET_BITS;
  localparam int LIT_TOKEN_BITS  = 9;
  localparam int PTR_TOKEN_BITS  = 1 + OFFSET_BITS + LEN_BITS;
  localparam int TOKEN_W         = PTR_TOKEN_BITS;
  localparam int CNT_W           = $clog2(PTR_TOKEN_BITS + 1);
  localparam int RUN_W           = LEN_BITS + 1;
  localparam int FILL_W          = OFFSET_BITS + 1;
  localparam int BYTE_W          = 8;

  localparam logic [OFFSET_BITS-1:0] WRITE_START =
    OFFSET_BITS'(RING_SIZE - (2 ** LEN_BITS + MIN_MATCH_BIAS));
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  // Queue depths, powers of two.
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              stream_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              run_last;
  } out_item_t;

  typedef struct packed {
    logic                   is_ptr;
    logic [BYTE_W-1:0]      lit;
    logic [OFFSET_BITS-1:0] pos;
    logic [LEN_BITS-1:0]    len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PRIME,
    BK_COPY
  } back_state_t;

endpackage

FILE: hw/rtl/lsd_front.sv
// ----------------------------------------------------------------------------
// lsd_front
// Shifts code bits MSB first into the token register and issues one command
// per finished literal or pointer token.
// ----------------------------------------------------------------------------
module lsd_front import lsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  input  q_stat_t  cmdq_stat,
  output logic     cmd_push,
  output cmd_t     cmd
);

  `include "assert_macros.svh"

  logic [TOKEN_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               tag_r, tag_nxt;
  logic               done;
  logic               accept;

  assign in_full  = cmdq_stat.full;
  assign accept   = in_push && !cmdq_stat.full;
  assign cmd_push = accept && done;

  always_comb begin
    logic b;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = tag_r;
    done      = 1'b0;
    cmd       = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      b = in_item.code_byte[BYTE_W-1-i];
      if (cnt_nxt == '0) tag_nxt = b;
      shift_nxt = {shift_nxt[TOKEN_W-2:0], b};
      cnt_nxt   = cnt_nxt + 1'b1;
      if (!tag_nxt && cnt_nxt == CNT_W'(LIT_TOKEN_BITS)) begin
        done       = 1'b1;
        cmd.is_ptr = 1'b0;
        cmd.lit    = shift_nxt[BYTE_W-1:0];
        shift_nxt  = '0;
        cnt_nxt    = '0;
      end else if (tag_nxt && cnt_nxt == CNT_W'(PTR_TOKEN_BITS)) begin
        done       = 1'b1;
        cmd.is_ptr = 1'b1;
        cmd.pos    = shift_nxt[OFFSET_BITS+LEN_BITS-1:LEN_BITS];
        cmd.len    = shift_nxt[LEN_BITS-1:0];
        shift_nxt  = '0;
        cnt_nxt    = '0;
      end
    end
    if (in_item.stream_end) begin
      shift_nxt = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      cnt_r   <= '0;
      tag_r   <= 1'b0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      tag_r   <= tag_nxt;
    end
  end

  // padding bits of the last byte never survive
  `LSD_ASSERT(a_end_clears, (accept && in_item.stream_end) |=> (cnt_r == '0), "token kept")

endmodule

FILE: hw/rtl/lsd_cmd_queue.sv
// ----------------------------------------------------------------------------
// lsd_cmd_queue
// Short command queue between token decode and the copy engine.
// ----------------------------------------------------------------------------
module lsd_cmd_queue import lsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t                  store_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  push_ok, pop_ok;

  assign stat.full  = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign head       = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) store_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_ok && !pop_ok)      cnt_r <= cnt_r + 1'b1;
      else if (pop_ok && !push_ok) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/lsd_back.sv
// ----------------------------------------------------------------------------
// lsd_back
// Copy engine: owns the history ring, emits literals and pointer copies one
// byte per cycle while the result queue has room, with same-cycle forwarding.
// ----------------------------------------------------------------------------
module lsd_back import lsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  q_stat_t   cmdq_stat,
  output logic      cmd_pop,
  input  q_stat_t   outq_stat,
  output logic      out_push,
  output out_item_t out_req
);

  `include "assert_macros.svh"

  logic [BYTE_W-1:0]      ring [RING_SIZE];
  back_state_t            state_r, state_nxt;
  logic [OFFSET_BITS-1:0] src_r, src_nxt;
  logic [OFFSET_BITS-1:0] cur_r, cur_nxt;
  logic [RUN_W-1:0]       remain_r, remain_nxt;
  logic [OFFSET_BITS-1:0] wp_r;
  logic [FILL_W-1:0]      fill_r;
  logic [BYTE_W-1:0]      rd_data_r;
  logic                   fwd_r;
  logic                   hit_r;
  logic [BYTE_W-1:0]      last_byte_r;
  logic [OFFSET_BITS-1:0] rd_addr;
  logic [OFFSET_BITS-1:0] rd_dist;
  logic                   fire;
  logic [BYTE_W-1:0]      byte_val;
  logic                   byte_last;

  // fill count: entry was written once its distance from the start is below it
  assign rd_dist = rd_addr - WRITE_START;

  always_comb begin
    state_nxt  = state_r;
    src_nxt    = src_r;
    cur_nxt    = cur_r;
    remain_nxt = remain_r;
    rd_addr    = cur_r;
    cmd_pop    = 1'b0;
    fire       = 1'b0;
    byte_val   = cmd.lit;
    byte_last  = 1'b1;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmdq_stat.empty) begin
          if (cmd.is_ptr) begin
            cmd_pop    = 1'b1;
            src_nxt    = cmd.pos;
            remain_nxt = RUN_W'(cmd.len) + RUN_W'(MIN_MATCH_BIAS + 1);
            state_nxt  = BK_PRIME;
          end else if (!outq_stat.full) begin
            cmd_pop = 1'b1;
            fire    = 1'b1;
          end
        end
      end
      BK_PRIME: begin
        rd_addr   = src_r;
        cur_nxt   = src_r;
        src_nxt   = src_r + 1'b1;
        state_nxt = BK_COPY;
      end
      BK_COPY: begin
        byte_val  = fwd_r ? last_byte_r : (hit_r ? rd_data_r : SPACE_CHAR);
        byte_last = (remain_r == RUN_W'(1));
        if (!outq_stat.full) begin
          fire       = 1'b1;
          remain_nxt = remain_r - 1'b1;
          if (byte_last) begin
            state_nxt = BK_IDLE;
          end else begin
            rd_addr = src_r;
            cur_nxt = src_r;
            src_nxt = src_r + 1'b1;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_push          = fire;
  assign out_req.data_byte = byte_val;
  assign out_req.run_last  = byte_last;

  always_ff @(posedge clk) begin
    if (fire) ring[wp_r] <= byte_val;
    rd_data_r <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    fwd_r <= fire && (rd_addr == wp_r);
    hit_r <= ({1'b0, rd_dist} < fill_r);
    src_r <= src_nxt;
    cur_r <= cur_nxt;
    remain_r <= remain_nxt;
    if (fire) last_byte_r <= byte_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      wp_r    <= WRITE_START;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        wp_r <= wp_r + 1'b1;
        if (fill_r != FILL_W'(RING_SIZE)) fill_r <= fill_r + 1'b1;
      end
    end
  end

  `LSD_ASSERT(a_prime_then_copy, (state_r == BK_PRIME) |=> (state_r == BK_COPY), "prime not followed by copy")
  `LSD_ASSERT(a_wp_step, fire |=> (wp_r == $past(wp_r) + 1'b1), "write position did not advance")
  `LSD_ASSERT(a_fill_bound, (fill_r <= FILL_W'(RING_SIZE)), "fill count beyond ring size")

endmodule

FILE: hw/rtl/lsd_out_queue.sv
// ----------------------------------------------------------------------------
// lsd_out_queue
// Result queue that decouples the copy engine from the consumer.
// ----------------------------------------------------------------------------
module lsd_out_queue import lsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  input  logic      pop,
  output out_item_t head,
  output q_stat_t   stat
);

  `include "assert_macros.svh"

  out_item_t             store_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0] cnt_r;
  logic                  push_ok, pop_ok;

  assign stat.full  = (cnt_r == OUTQ_CNT_W'(OUTQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign head       = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) store_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_ok && !pop_ok)      cnt_r <= cnt_r + 1'b1;
      else if (pop_ok && !push_ok) cnt_r <= cnt_r - 1'b1;
    end
  end

  `LSD_ASSERT(a_pop_count, (pop_ok && !push_ok) |=> (cnt_r == $past(cnt_r) - 1'b1), "count not reduced on pop")

endmodule

FILE: hw/rtl/lzss_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder_core
// LZSS decoder, 11-bit ring position, 4-bit length, 2048-byte history ring.
//
//   channel | ports                      | carries
//   in      | in_push, in_full, in_item  | one code byte, end-of-stream flag
//   out     | out_pop, out_empty, out_item | one decoded byte, last-of-run flag
//
// A code byte is taken whenever the command queue has room.
// Literal: sent from the copy engine's idle state. Pointer of run N: a priming
// read, then N bytes, one per cycle through the ring's single read port.
// Reset is synchronous; the ring needs no clearing pass, unwritten entries
// read as space through a fill count.
// A full result queue stalls the copy engine; a full command queue stalls in.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_core import lsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic      cmd_push;
  cmd_t      cmd_new;
  cmd_t      cmd_head;
  logic      cmd_pop;
  q_stat_t   cmdq_stat;
  q_stat_t   outq_stat;
  logic      res_push;
  out_item_t res_req;

  lsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmdq_stat (cmdq_stat),
    .cmd_push  (cmd_push),
    .cmd       (cmd_new)
  );

  lsd_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_new),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .stat     (cmdq_stat)
  );

  lsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_head),
    .cmdq_stat (cmdq_stat),
    .cmd_pop   (cmd_pop),
    .outq_stat (outq_stat),
    .out_push  (res_push),
    .out_req   (res_req)
  );

  lsd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_req),
    .pop       (out_pop),
    .head      (out_item),
    .stat      (outq_stat)
  );

  assign out_empty = outq_stat.empty;

endmodule

FILE: tb/sv/tb_lzss_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzss_stream_decoder_core
// Self-checking bench for the LZSS stream decoder core.
// Encoded token streams (literals, ring copies, truncated tokens, noise) are
// packed MSB first into code bytes and pushed with random gaps. A local
// decoder with its own history ring predicts every decoded byte and its
// last-of-run flag, and each popped result is compared against that.
// ----------------------------------------------------------------------------
module tb_lzss_stream_decoder_core;
  import lsd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 310;
  localparam int QUIET_TAIL   = 40;
  localparam int MAX_SHOWN    = 10;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  lzss_stream_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // Local decoder state
  logic [BYTE_W-1:0]      hist_ring [RING_SIZE];
  logic [OFFSET_BITS-1:0] pred_wpos;
  logic [TOKEN_W-1:0]     tok_shift;
  int                     tok_count;
  logic [BYTE_W-1:0]      run_bytes [$];
  out_item_t              expected_bytes [$];

  bit code_bits [$];

  bit send_idle_en;
  bit pop_idle_en;
  int pop_stall_left;
  int cycle_count;
  int error_count;
  int items_sent;
  int bytes_checked;
  int lit_tokens;
  int ptr_tokens;
  int stream_ends;
  out_item_t exp_item;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_bytes.size());
      $display("FAIL lzss_stream_decoder_core");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("[%0t] %s", $time, msg);
  endfunction

  task automatic record_byte(input logic [BYTE_W-1:0] b);
    hist_ring[pred_wpos] = b;
    pred_wpos = pred_wpos + 1'b1;
    run_bytes.push_back(b);
  endtask

  // Bit-serial decode of one accepted code byte.
  task automatic decode_code_byte(input in_item_t it);
    logic [OFFSET_BITS-1:0] rd_pos;
    logic                   tag;
    int                     run_len;
    int                     i;
    int                     k;
    out_item_t              res;
    run_bytes.delete();
    for (i = BYTE_W - 1; i >= 0; i--) begin
      tok_shift = {tok_shift[TOKEN_W-2:0], it.code_byte[i]};
      tok_count++;
      tag = tok_shift[tok_count-1];
      if (!tag && tok_count == LIT_TOKEN_BITS) begin
        record_byte(tok_shift[BYTE_W-1:0]);
        lit_tokens++;
        tok_shift = '0;
        tok_count = 0;
      end else if (tag && tok_count == PTR_TOKEN_BITS) begin
        rd_pos  = tok_shift[LEN_BITS +: OFFSET_BITS];
        run_len = int'(tok_shift[LEN_BITS-1:0]) + MIN_MATCH_BIAS + 1;
        // byte by byte, so an overlapping copy sees its own output
        for (k = 0; k < run_len; k++) begin
          record_byte(hist_ring[rd_pos]);
          rd_pos = rd_pos + 1'b1;
        end
        ptr_tokens++;
        tok_shift = '0;
        tok_count = 0;
      end
    end
    if (it.stream_end) begin
      tok_shift = '0;
      tok_count = 0;
      stream_ends++;
    end
    for (k = 0; k < run_bytes.size(); k++) begin
      res.data_byte = run_bytes[k];
      res.run_last  = (k == run_bytes.size() - 1);
      expected_bytes.push_back(res);
    end
  endtask

  // One request on the input side; returns at the accepting edge.
  task automatic send_code(input logic [BYTE_W-1:0] b, input logic e);
    int gap;
    @(negedge clk);
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push             = 1'b1;
    in_item.code_byte   = b;
    in_item.stream_end  = e;
    do @(posedge clk); while (in_full);
    decode_code_byte(in_item);
    items_sent++;
  endtask

  task automatic in_idle();
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic wait_drained();
    in_idle();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_token(input logic [TOKEN_W-1:0] value, input int nbits);
    int i;
    for (i = nbits - 1; i >= 0; i--) code_bits.push_back(value[i]);
  endtask

  task automatic queue_literal(input logic [BYTE_W-1:0] b);
    queue_token(TOKEN_W'({1'b0, b}), LIT_TOKEN_BITS);
  endtask

  task automatic queue_pointer(input logic [OFFSET_BITS-1:0] pos,
                               input logic [LEN_BITS-1:0] len);
    queue_token({1'b1, pos, len}, PTR_TOKEN_BITS);
  endtask

  // Send all whole bytes; with end_stream, pad the tail and flag it.
  task automatic flush_code_bits(input bit end_stream);
    logic [BYTE_W-1:0] b;
    int k;
    while (code_bits.size() >= BYTE_W) begin
      for (k = BYTE_W - 1; k >= 0; k--) b[k] = code_bits.pop_front();
      send_code(b, end_stream && code_bits.size() == 0);
    end
    if (end_stream && code_bits.size() > 0) begin
      b = BYTE_W'($urandom);
      for (k = BYTE_W - 1; code_bits.size() > 0; k--) b[k] = code_bits.pop_front();
      send_code(b, 1'b1);
    end
  endtask

  task automatic test_literals();
    queue_literal(8'h00);
    queue_literal(8'hFF);
    queue_literal(8'hA5);
    queue_literal(8'h5A);
    // untouched ring area still reads as spaces
    queue_pointer('0, '0);
    flush_code_bits(1'b1);
  endtask

  task automatic test_pointers();
    // copy running off the top of the ring, longest run
    queue_pointer('1, '1);
    flush_code_bits(1'b1);
    // source one behind the write position: repeats the last byte
    queue_pointer(pred_wpos - 1'b1, '1);
    queue_pointer(WRITE_START, '0);
    flush_code_bits(1'b1);
  endtask

  task automatic test_stream_end();
    queue_token(16'b0_1011, 5);
    flush_code_bits(1'b1);
    queue_token(TOKEN_W'({1'b1, 11'h3C5}), 12);
    flush_code_bits(1'b1);
    // literal completes in the flagged byte, padding follows it
    queue_literal(8'h41);
    flush_code_bits(1'b1);
    wait_drained();
  endtask

  task automatic test_random_stream();
    int first;
    int r;
    int n;
    int j;
    bit paused;
    logic [OFFSET_BITS-1:0] pos;
    first  = items_sent;
    paused = 1'b0;
    while (items_sent < first + RANDOM_ITEMS) begin
      if (items_sent >= first + RANDOM_ITEMS - QUIET_TAIL) begin
        send_idle_en = 1'b0;
        pop_idle_en  = 1'b0;
      end
      if (!paused && items_sent >= first + RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_literal(BYTE_W'($urandom_range(0, 255)));
      end else if (r < 85) begin
        case ($urandom_range(0, 2))
          0: pos = pred_wpos - OFFSET_BITS'($urandom_range(1, 20));
          1: pos = OFFSET_BITS'(RING_SIZE - $urandom_range(1, 16));
          default: pos = OFFSET_BITS'($urandom);
        endcase
        queue_pointer(pos, LEN_BITS'($urandom));
      end else if (r < 93) begin
        if ($urandom_range(0, 1))
          queue_token(TOKEN_W'($urandom), $urandom_range(1, PTR_TOKEN_BITS - 1));
        flush_code_bits(1'b1);
      end else begin
        // noise burst, closed by a flagged byte to resync
        flush_code_bits(1'b1);
        n = $urandom_range(1, 4);
        for (j = 0; j < n; j++) send_code(BYTE_W'($urandom), j == n - 1);
      end
      flush_code_bits(1'b0);
    end
    flush_code_bits(1'b1);
  endtask

  always @(negedge clk) begin
    if (pop_stall_left > 0) begin
      out_pop        <= 1'b0;
      pop_stall_left <= pop_stall_left - 1;
    end else if (pop_idle_en && $urandom_range(0, 4) == 0) begin
      out_pop        <= 1'b0;
      pop_stall_left <= $urandom_range(0, 4);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected result: byte %02h last %0b",
                               out_item.data_byte, out_item.run_last));
      end else begin
        exp_item = expected_bytes.pop_front();
        if (out_item.data_byte !== exp_item.data_byte ||
            out_item.run_last !== exp_item.run_last)
          note_failure($sformatf("result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                 bytes_checked, exp_item.data_byte, exp_item.run_last,
                                 out_item.data_byte, out_item.run_last));
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_item        = '0;
    out_pop        = 1'b0;
    pop_stall_left = 0;
    cycle_count    = 0;
    error_count    = 0;
    items_sent     = 0;
    bytes_checked  = 0;
    lit_tokens     = 0;
    ptr_tokens     = 0;
    stream_ends    = 0;
    send_idle_en   = 1'b1;
    pop_idle_en    = 1'b1;
    foreach (hist_ring[i]) hist_ring[i] = SPACE_CHAR;
    pred_wpos = WRITE_START;
    tok_shift = '0;
    tok_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_literals();
    test_pointers();
    test_stream_end();
    test_random_stream();
    wait_drained();

    if (expected_bytes.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", expected_bytes.size());
    end
    $display("Decoded %0d code bytes: %0d literals, %0d ring copies, %0d stream ends.",
             items_sent, lit_tokens, ptr_tokens, stream_ends);
    $display("Checked %0d output bytes, %0d failures.", bytes_checked, error_count);
    if (error_count == 0) begin
      $display("PASS lzss_stream_decoder_core");
    end else begin
      $display("FAIL lzss_stream_decoder_core");
    end
    $finish;
  end

endmodule
